>>> hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int unsigned ITEM_W = 32;
	localparam int unsigned PRIO_W = 16;
	localparam int unsigned CAP_W  = 6;
	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	typedef enum logic {
		CMD_ENQUEUE = 1'b0,
		CMD_DEQUEUE = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_REMOVED  = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		command_t                  command;
		logic signed [ITEM_W-1:0]  item_value;
		logic        [PRIO_W-1:0]  priority_value;
	} req_item_t;

	typedef struct packed {
		status_t                   status;
		logic signed [ITEM_W-1:0]  removed_item;
	} rsp_item_t;

	typedef struct packed {
		logic signed [ITEM_W-1:0]  item;
		logic        [PRIO_W-1:0]  prio;
	} entry_t;

	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t entry;
	} cell_ctrl_t;

endpackage

>>> hdl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue kept sorted in a row of shifting cells; head at
// cell 0, equal priorities served newest first.
// ----------------------------------------------------------------------------
//  channel | direction | payload     | meaning
//  req     | in        | req_item_t  | enqueue or dequeue command
//  rsp     | out       | rsp_item_t  | status and removed item
//  cfg     | in        | cfg_data    | capacity register write
//
//  one item per cycle while req_ready is high; each command updates the cell row as it is taken
//  the result is registered and offered the cycle after its item is taken
//  req_ready drops only while that register is full and rsp_ready is low
//  reset empties the queue and sets capacity to 32; cfg_ready is always high
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit import spq_pkg::*; #(
	parameter int unsigned DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_item_t        req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_item_t        rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [CNT_W-1:0] count_q;
	logic [CAP_W-1:0] capacity_q;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;

	logic       fire;
	logic       full;
	logic       empty;
	cell_ctrl_t ctrl;
	entry_t     cell_entry [DEPTH];
	logic       cell_ge    [DEPTH];
	logic       cell_valid [DEPTH];

	assign cfg_ready = 1'b1;
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign fire      = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign full  = (CMP_W'(count_q) >= CMP_W'(capacity_q)) ||
	               (CMP_W'(count_q) >= CMP_W'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		ctrl.enq        = fire && (req.command == CMD_ENQUEUE) && !full;
		ctrl.deq        = fire && (req.command == CMD_DEQUEUE) && !empty;
		ctrl.entry.item = req.item_value;
		ctrl.entry.prio = req.priority_value;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign cell_valid[i] = (count_q > CNT_W'(i));
		if (i == 0) begin : g_head
			spq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.valid       (cell_valid[i]),
				.left_ge     (1'b0),
				.left_entry  (ctrl.entry),
				.right_entry (cell_entry[i+1]),
				.entry       (cell_entry[i]),
				.ge          (cell_ge[i])
			);
		end else if (i == DEPTH - 1) begin : g_tail
			spq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.valid       (cell_valid[i]),
				.left_ge     (cell_ge[i-1]),
				.left_entry  (cell_entry[i-1]),
				.right_entry (cell_entry[i]),
				.entry       (cell_entry[i]),
				.ge          (cell_ge[i])
			);
		end else begin : g_mid
			spq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.valid       (cell_valid[i]),
				.left_ge     (cell_ge[i-1]),
				.left_entry  (cell_entry[i-1]),
				.right_entry (cell_entry[i+1]),
				.entry       (cell_entry[i]),
				.ge          (cell_ge[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.enq) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctrl.deq) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			case (req.command)
				CMD_ENQUEUE: begin
					rsp_q.status       <= full ? ST_FULL : ST_INSERTED;
					rsp_q.removed_item <= '0;
				end
				CMD_DEQUEUE: begin
					if (empty) begin
						rsp_q.status       <= ST_EMPTY;
						rsp_q.removed_item <= '0;
					end else begin
						rsp_q.status       <= ST_REMOVED;
						rsp_q.removed_item <= cell_entry[0].item;
					end
				end
				default: begin
					rsp_q.status       <= ST_EMPTY;
					rsp_q.removed_item <= '0;
				end
			endcase
		end
	end

endmodule

>>> hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds, takes the new entry or shifts right on
// insert, shifts left on removal.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       valid,
	input  logic       left_ge,
	input  entry_t     left_entry,
	input  entry_t     right_entry,
	output entry_t     entry,
	output logic       ge
);

	entry_t entry_q;

	assign entry = entry_q;
	// slot is empty or holds a priority not smaller than the new one
	assign ge = !valid || (entry_q.prio >= ctrl.entry.prio);

	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (ge && left_ge) begin
				entry_q <= left_entry;
			end else if (ge) begin
				entry_q <= ctrl.entry;
			end
		end else if (ctrl.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule
